>>> hdl/mmh64_pkg.sv
// mmh64_pkg: shared types and constants for the 64-bit murmur hash core
// used by the controller, the datapath and the top level; no dependencies
package mmh64_pkg;

   localparam logic [31:0] MixMul   = 32'h5bd1_e995;
   localparam int          MixShift = 24;
   localparam int          AvShift1 = 18;
   localparam int          AvShift2 = 22;
   localparam int          AvShift3 = 17;
   localparam int          AvShift4 = 19;

   localparam int WordWidth  = 32;
   localparam int CountWidth = 3;
   localparam int DigWidth   = 64;
   localparam int LenWidth   = 16;
   localparam int ReqWidth   = 104;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MIX,
      ST_LANE,
      ST_AV1,
      ST_AV2,
      ST_AV3,
      ST_AV4,
      ST_EMIT
   } state_type;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_ACCEPT,
      OP_K2,
      OP_LANE,
      OP_TAIL,
      OP_AV1,
      OP_AV2,
      OP_AV3,
      OP_AV4,
      OP_EMIT
   } op_type;

   typedef struct packed {
      op_type op;
   } cmd_type;

   typedef struct packed {
      logic full_word;
      logic zero_word;
      logic final_word;
   } status_type;

endpackage

>>> hdl/mmh64_dp.sv
// mmh64_dp: hash datapath with the two lanes, the word key and one shared
// constant multiplier; driven by commands from mmh64_ctrl, uses mmh64_pkg
module mmh64_dp (
   input  logic                                clock,
   input  logic                                reset,
   input  mmh64_pkg::cmd_type                  cmd,
   output mmh64_pkg::status_type               status,
   input  logic [mmh64_pkg::WordWidth-1:0]     in_word,
   input  logic [mmh64_pkg::CountWidth-1:0]    in_count,
   input  logic                                in_last,
   input  logic [mmh64_pkg::DigWidth-1:0]      in_expected,
   input  logic                                csr_we,
   input  logic [mmh64_pkg::LenWidth-1:0]      csr_wdata,
   output logic [mmh64_pkg::DigWidth-1:0]      out_digest,
   output logic                                out_match
);
   import mmh64_pkg::*;

   logic [LenWidth-1:0]   len_ff;
   logic [WordWidth-1:0]  lane1_ff, lane1_in;
   logic [WordWidth-1:0]  lane2_ff, lane2_in;
   logic                  parity_ff, parity_in;
   logic [WordWidth-1:0]  key_ff, key_in;
   logic [WordWidth-1:0]  word_ff;
   logic [CountWidth-1:0] count_ff;
   logic                  last_ff;
   logic [DigWidth-1:0]   expect_ff;
   logic [DigWidth-1:0]   digest_ff, digest_in;
   logic                  match_ff, match_in;
   logic [WordWidth-1:0]  mul_a;
   logic [WordWidth-1:0]  mul_p;
   logic [WordWidth-1:0]  tail_mask;
   logic [DigWidth-1:0]   digest_now;

   always_comb begin
      unique case (count_ff)
         3'd1:    tail_mask = 32'h0000_00ff;
         3'd2:    tail_mask = 32'h0000_ffff;
         3'd3:    tail_mask = 32'h00ff_ffff;
         default: tail_mask = '0;
      endcase
   end

   assign status.full_word  = count_ff[2];
   assign status.zero_word  = (count_ff == '0);
   assign status.final_word = last_ff | ~count_ff[2];

   // one multiplier shared by every multiply step, low half of the product only
   always_comb begin
      unique case (cmd.op)
         OP_ACCEPT: mul_a = in_word;
         OP_K2:     mul_a = key_ff ^ (key_ff >> MixShift);
         OP_LANE:   mul_a = parity_ff ? lane2_ff : lane1_ff;
         OP_TAIL:   mul_a = lane2_ff ^ (word_ff & tail_mask);
         OP_AV1:    mul_a = lane1_ff ^ (lane2_ff >> AvShift1);
         OP_AV2:    mul_a = lane2_ff ^ (lane1_ff >> AvShift2);
         OP_AV3:    mul_a = lane1_ff ^ (lane2_ff >> AvShift3);
         OP_AV4:    mul_a = lane2_ff ^ (lane1_ff >> AvShift4);
         default:   mul_a = '0;
      endcase
   end

   assign mul_p      = mul_a * MixMul;
   assign digest_now = {lane2_ff, lane1_ff};

   always_comb begin
      lane1_in  = lane1_ff;
      lane2_in  = lane2_ff;
      parity_in = parity_ff;
      key_in    = key_ff;
      digest_in = digest_ff;
      match_in  = match_ff;
      unique case (cmd.op)
         OP_ACCEPT: key_in = mul_p;
         OP_K2:     key_in = mul_p;
         OP_LANE: begin
            if (parity_ff) begin
               lane2_in = mul_p ^ key_ff;
            end else begin
               lane1_in = mul_p ^ key_ff;
            end
            parity_in = ~parity_ff;
         end
         OP_TAIL:   lane2_in = mul_p;
         OP_AV1:    lane1_in = mul_p;
         OP_AV2:    lane2_in = mul_p;
         OP_AV3:    lane1_in = mul_p;
         OP_AV4:    lane2_in = mul_p;
         OP_EMIT: begin
            digest_in = digest_now;
            match_in  = (digest_now == expect_ff);
            lane1_in  = WordWidth'(len_ff);
            lane2_in  = '0;
            parity_in = 1'b0;
         end
         default: begin
         end
      endcase
      // a length write restarts the message
      if (csr_we) begin
         lane1_in  = WordWidth'(csr_wdata);
         lane2_in  = '0;
         parity_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff    <= '0;
         lane1_ff  <= '0;
         lane2_ff  <= '0;
         parity_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            len_ff <= csr_wdata;
         end
         lane1_ff  <= lane1_in;
         lane2_ff  <= lane2_in;
         parity_ff <= parity_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff    <= key_in;
      digest_ff <= digest_in;
      match_ff  <= match_in;
      if (cmd.op == OP_ACCEPT) begin
         word_ff   <= in_word;
         count_ff  <= in_count;
         last_ff   <= in_last;
         expect_ff <= in_expected;
      end
   end

   assign out_digest = digest_ff;
   assign out_match  = match_ff;

`ifndef SYNTH
   a_lane_flips_parity: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == OP_LANE && !csr_we) |=> (parity_ff != $past(parity_ff)))
      else $error("parity did not alternate after a lane update");

   a_csr_restarts: assert property (@(posedge clock) disable iff (reset)
      csr_we |=> (lane2_ff == '0 && !parity_ff && lane1_ff == WordWidth'(len_ff)))
      else $error("length write did not restart the lanes");

   a_emit_restarts: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == OP_EMIT && !csr_we) |=> (lane2_ff == '0 && !parity_ff))
      else $error("lanes not reloaded after digest");
`endif

endmodule

>>> hdl/mmh64_ctrl.sv
// mmh64_ctrl: sequencer for the murmur hash core, one word at a time
// issues datapath commands and owns both handshakes; uses mmh64_pkg
module mmh64_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   input  mmh64_pkg::status_type   status,
   output mmh64_pkg::cmd_type      cmd
);
   import mmh64_pkg::*;

   state_type state_ff, state_in;
   logic      valid_ff, valid_in;
   logic      slot_free;

   assign slot_free  = ~valid_ff | rsp_tready;
   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd.op   = OP_NONE;
      valid_in = valid_ff & ~rsp_tready;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.op   = OP_ACCEPT;
               state_in = ST_MIX;
            end
         end
         ST_MIX: begin
            if (status.full_word) begin
               cmd.op   = OP_K2;
               state_in = ST_LANE;
            end else if (status.zero_word) begin
               state_in = ST_AV1;
            end else begin
               cmd.op   = OP_TAIL;
               state_in = ST_AV1;
            end
         end
         ST_LANE: begin
            cmd.op   = OP_LANE;
            state_in = status.final_word ? ST_AV1 : ST_IDLE;
         end
         ST_AV1: begin
            cmd.op   = OP_AV1;
            state_in = ST_AV2;
         end
         ST_AV2: begin
            cmd.op   = OP_AV2;
            state_in = ST_AV3;
         end
         ST_AV3: begin
            cmd.op   = OP_AV3;
            state_in = ST_AV4;
         end
         ST_AV4: begin
            cmd.op   = OP_AV4;
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            // wait here while the previous digest is still held
            if (slot_free) begin
               cmd.op   = OP_EMIT;
               valid_in = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

`ifndef SYNTH
   a_emit_waits: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT && valid_ff && !rsp_tready) |=> (state_ff == ST_EMIT))
      else $error("digest emitted over an untaken beat");

   a_rsp_from_emit: assert property (@(posedge clock) disable iff (reset)
      $rose(valid_ff) |-> ($past(state_ff) == ST_EMIT))
      else $error("result raised outside the emit step");

   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> (state_ff == ST_MIX))
      else $error("accepted word did not start mixing");
`endif

endmodule

>>> hdl/murmur_hash_64b_core.sv
// murmur_hash_64b_core: 64-bit murmur hash (seed zero) over one message per run
// instantiates mmh64_ctrl and mmh64_dp; uses mmh64_pkg
//
//   channel | dir | payload                                         | handshake
//   req_    | in  | data_word, byte_count, expected_digest; tlast   | tvalid/tready
//   rsp_    | out | digest; tuser = match                           | tvalid/tready
//   csr_    | in  | message_length                                  | write enable
//
// a full word passes through accept, key mix and lane update, a partial
// final word through accept and tail, and an empty one through accept
// alone, all through one shared 32-bit constant multiplier; any final word
// then adds the four avalanche steps and the digest write-out.
// synchronous active-high reset clears the length register and the lanes.
// a finished digest waits in the output register; the core accepts the next
// word while it waits and only holds before writing another digest.
module murmur_hash_64b_core (
   input  logic                              clock,
   input  logic                              reset,
   // data_word[31:0], byte_count[34:32], expected_digest[98:35], zero fill
   input  logic [mmh64_pkg::ReqWidth-1:0]    req_tdata,
   input  logic                              req_tlast,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // digest[63:0]
   output logic [mmh64_pkg::DigWidth-1:0]    rsp_tdata,
   // match[0]
   output logic                              rsp_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   input  logic                              csr_we,
   input  logic [mmh64_pkg::LenWidth-1:0]    csr_wdata
);
   import mmh64_pkg::*;

   cmd_type    cmd;
   status_type status;

   mmh64_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   mmh64_dp u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .in_word     (req_tdata[WordWidth-1:0]),
      .in_count    (req_tdata[WordWidth+CountWidth-1:WordWidth]),
      .in_last     (req_tlast),
      .in_expected (req_tdata[WordWidth+CountWidth+DigWidth-1:WordWidth+CountWidth]),
      .csr_we      (csr_we),
      .csr_wdata   (csr_wdata),
      .out_digest  (rsp_tdata),
      .out_match   (rsp_tuser)
   );

endmodule
